@@ rtl/qdfg_pkg.sv @@
// Package for the QoS dead-band frequency governor.
// Holds field widths, reset values, register and action codes, shared structs.
// No dependencies.
package qdfg_pkg;

    localparam int NUM_CORES    = 16;
    localparam int CORE_W       = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CORE_FIELD_W = 4;
    localparam int RATE_W       = 24;
    localparam int FREQ_W       = 16;
    localparam int MARGIN_W     = 16;
    localparam int STEP_W       = 12;
    localparam int ACT_W        = 3;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [FREQ_W-1:0]   MAX_FREQ_RST = 16'd4000;
    localparam logic [FREQ_W-1:0]   MIN_FREQ_RST = 16'd1000;
    localparam logic [MARGIN_W-1:0] MARGIN_RST   = 16'd256;
    localparam logic [STEP_W-1:0]   STEP_RST     = 12'd100;
    // Minus one: no rate seen yet
    localparam logic [RATE_W-1:0]   RATE_NONE    = {RATE_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_NO_APP  = 3'd0,
        ACT_NO_DATA = 3'd1,
        ACT_STALE   = 3'd2,
        ACT_UNSET   = 3'd3,
        ACT_ERROR   = 3'd4,
        ACT_HOLD    = 3'd5,
        ACT_DOWN    = 3'd6,
        ACT_UP      = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        REG_MAX_FREQ = 2'd0,
        REG_MIN_FREQ = 2'd1,
        REG_MARGIN   = 2'd2,
        REG_STEP     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   max_freq;
        logic [FREQ_W-1:0]   min_freq;
        logic [MARGIN_W-1:0] margin;
        logic [STEP_W-1:0]   step;
    } cfg_t;

    typedef struct packed {
        logic [FREQ_W-1:0] new_freq;
        action_t           action;
        logic              store_we;
    } decision_t;

endpackage

@@ rtl/qdfg_if.sv @@
// Stream interfaces for the governor: report channel and decision channel.
// Depends on qdfg_pkg.
interface qdfg_req_if;
    logic                                    valid;
    logic                                    ready;
    logic        [qdfg_pkg::CORE_FIELD_W-1:0] core_index;
    logic                                    has_app;
    logic signed [qdfg_pkg::RATE_W-1:0]      current_rate;
    logic signed [qdfg_pkg::RATE_W-1:0]      target_rate;
    logic        [qdfg_pkg::FREQ_W-1:0]      old_freq;

    modport source (
        output valid, core_index, has_app, current_rate, target_rate, old_freq,
        input  ready
    );
    modport sink (
        input  valid, core_index, has_app, current_rate, target_rate, old_freq,
        output ready
    );
endinterface

interface qdfg_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [qdfg_pkg::FREQ_W-1:0]      new_freq;
    qdfg_pkg::action_t                action;

    modport source (
        output valid, new_freq, action,
        input  ready
    );
    modport sink (
        input  valid, new_freq, action,
        output ready
    );
endinterface

@@ rtl/qdfg_decide.sv @@
// Decision logic of the governor: applies the ordered rules to one report.
// Purely combinational; depends on qdfg_pkg.
module qdfg_decide (
    input  qdfg_pkg::cfg_t                     cfg,
    input  logic                               has_app,
    input  logic signed [qdfg_pkg::RATE_W-1:0] rate,
    input  logic signed [qdfg_pkg::RATE_W-1:0] target,
    input  logic        [qdfg_pkg::FREQ_W-1:0] old_freq,
    input  logic signed [qdfg_pkg::RATE_W-1:0] stored,
    output qdfg_pkg::decision_t                dec
);
    import qdfg_pkg::*;

    localparam int BAND_W = RATE_W + 3;

    logic signed [BAND_W-1:0] r2;
    logic signed [BAND_W-1:0] t2;
    logic signed [BAND_W-1:0] m;
    logic signed [BAND_W-1:0] lo;
    logic signed [BAND_W-1:0] hi;
    logic                     in_band;
    logic                     stale;
    logic [FREQ_W-1:0]        step_ext;
    logic [FREQ_W:0]          up_sum;
    logic [FREQ_W-1:0]        down_freq;
    logic [FREQ_W-1:0]        up_freq;

    // Exact band test on doubled rates, so an odd margin needs no rounding
    assign r2 = {{2{rate[RATE_W-1]}}, rate, 1'b0};
    assign t2 = {{2{target[RATE_W-1]}}, target, 1'b0};
    assign m  = {{(BAND_W-MARGIN_W){1'b0}}, cfg.margin};
    assign lo = t2 - m;
    assign hi = t2 + m;
    assign in_band = (r2 >= lo) && (r2 <= hi);

    assign stale     = (rate == stored);
    assign step_ext  = {{(FREQ_W-STEP_W){1'b0}}, cfg.step};
    assign down_freq = (old_freq >= step_ext) ? (old_freq - step_ext) : '0;
    assign up_sum    = {1'b0, old_freq} + {1'b0, step_ext};
    assign up_freq   = up_sum[FREQ_W] ? {FREQ_W{1'b1}} : up_sum[FREQ_W-1:0];

    always_comb
    begin
        dec.store_we = has_app && !rate[RATE_W-1] && !stale;
        priority if (!has_app)
        begin
            dec.new_freq = cfg.min_freq;
            dec.action   = ACT_NO_APP;
        end
        else if (rate[RATE_W-1])
        begin
            dec.new_freq = cfg.max_freq;
            dec.action   = ACT_NO_DATA;
        end
        else if (stale)
        begin
            dec.new_freq = old_freq;
            dec.action   = ACT_STALE;
        end
        else if (target == '0)
        begin
            dec.new_freq = cfg.max_freq;
            dec.action   = ACT_UNSET;
        end
        else if (target[RATE_W-1])
        begin
            dec.new_freq = old_freq;
            dec.action   = ACT_ERROR;
        end
        else if (in_band)
        begin
            dec.new_freq = old_freq;
            dec.action   = ACT_HOLD;
        end
        else if (rate > target)
        begin
            dec.new_freq = down_freq;
            dec.action   = ACT_DOWN;
        end
        else
        begin
            dec.new_freq = up_freq;
            dec.action   = ACT_UP;
        end
    end

endmodule

@@ rtl/qos_deadband_frequency_governor.sv @@
// Top level of the QoS dead-band frequency governor.
// Input register, per-core last-rate store, decision logic, result register, APB regs.
// Depends on qdfg_pkg, qdfg_if, qdfg_decide.
//
//   channel   direction  handshake          carries
//   req       in         valid/ready        core_index, has_app, rates, old_freq
//   rsp       out        valid/ready        new_freq, action
//   apb       in         psel/penable       register writes and reads, pready tied high
//
// One report per cycle while rsp is not stalled; the result passes the input register
// and then the result register before rsp.valid rises.
// The per-core rate store is read and written in the decision stage, so back-to-back
// reports to one core see each other in order without forwarding.
// Reset clears valids, the rate store (to minus one) and the registers to defaults.
// A stalled rsp holds the result; req still takes one more transaction into the input stage.
module qos_deadband_frequency_governor (
    input  logic                          clk,
    input  logic                          rst_n,
    qdfg_req_if.sink                      req,
    qdfg_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qdfg_pkg::ADDR_W-1:0]   paddr,
    input  logic [qdfg_pkg::DATA_W-1:0]   pwdata,
    output logic [qdfg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import qdfg_pkg::*;

    cfg_t                      cfg_reg;
    cfg_reg_t                  cfg_sel;
    logic                      cfg_write;

    logic                      s1_valid_reg;
    logic [CORE_FIELD_W-1:0]   s1_core_reg;
    logic                      s1_has_app_reg;
    logic signed [RATE_W-1:0]  s1_rate_reg;
    logic signed [RATE_W-1:0]  s1_target_reg;
    logic [FREQ_W-1:0]         s1_old_reg;

    logic                      out_valid_reg;
    logic [FREQ_W-1:0]         out_freq_reg;
    action_t                   out_action_reg;

    logic [RATE_W-1:0]         last_rate_reg [NUM_CORES];

    logic                      advance;
    logic                      accept;
    logic                      have_reg;
    logic [CORE_W-1:0]         core_idx;
    logic signed [RATE_W-1:0]  stored;
    decision_t                 dec;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_freq <= MAX_FREQ_RST;
            cfg_reg.min_freq <= MIN_FREQ_RST;
            cfg_reg.margin   <= MARGIN_RST;
            cfg_reg.step     <= STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_MAX_FREQ: cfg_reg.max_freq <= pwdata[FREQ_W-1:0];
                REG_MIN_FREQ: cfg_reg.min_freq <= pwdata[FREQ_W-1:0];
                REG_MARGIN:   cfg_reg.margin   <= pwdata[MARGIN_W-1:0];
                REG_STEP:     cfg_reg.step     <= pwdata[STEP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_MAX_FREQ: prdata = {{(DATA_W-FREQ_W){1'b0}}, cfg_reg.max_freq};
            REG_MIN_FREQ: prdata = {{(DATA_W-FREQ_W){1'b0}}, cfg_reg.min_freq};
            REG_MARGIN:   prdata = {{(DATA_W-MARGIN_W){1'b0}}, cfg_reg.margin};
            REG_STEP:     prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_reg.step};
        endcase
    end

    // ---------------- handshake ----------------
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept || advance)
            begin
                s1_valid_reg <= accept;
            end
            if (advance || rsp.ready)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_core_reg    <= req.core_index;
            s1_has_app_reg <= req.has_app;
            s1_rate_reg    <= req.current_rate;
            s1_target_reg  <= req.target_rate;
            s1_old_reg     <= req.old_freq;
        end
        if (advance)
        begin
            out_freq_reg   <= dec.new_freq;
            out_action_reg <= dec.action;
        end
    end

    // ---------------- per-core rate store ----------------
    assign have_reg = ({{(32-CORE_FIELD_W){1'b0}}, s1_core_reg} < 32'(NUM_CORES));
    assign core_idx = CORE_W'(s1_core_reg);
    assign stored   = have_reg ? $signed(last_rate_reg[core_idx]) : $signed(RATE_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CORES; i++)
            begin
                last_rate_reg[i] <= RATE_NONE;
            end
        end
        else if (advance && dec.store_we && have_reg)
        begin
            last_rate_reg[core_idx] <= s1_rate_reg;
        end
    end

    qdfg_decide u_decide (
        .cfg      (cfg_reg),
        .has_app  (s1_has_app_reg),
        .rate     (s1_rate_reg),
        .target   (s1_target_reg),
        .old_freq (s1_old_reg),
        .stored   (stored),
        .dec      (dec)
    );

    assign rsp.valid    = out_valid_reg;
    assign rsp.new_freq = out_freq_reg;
    assign rsp.action   = out_action_reg;

endmodule

@@ rtl/qdfg_checker.sv @@
// Port-level checker for the governor, attached to the top level by bind.
// Depends on qdfg_pkg.
module qdfg_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [qdfg_pkg::FREQ_W-1:0] rsp_new_freq,
    input qdfg_pkg::action_t           rsp_action
);
    import qdfg_pkg::*;

    // A held result keeps its payload until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_new_freq) && $stable(rsp_action))
        else $error("rsp payload changed while stalled");

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("rsp valid during reset");

    // An empty result register always lets the input stage drain
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("req not ready with empty result register");

    // Taken while rsp is empty, a transaction passes input and result registers to rsp
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
        else $error("result missing two cycles after transaction");

endmodule

bind qos_deadband_frequency_governor qdfg_checker u_qdfg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_new_freq (rsp.new_freq),
    .rsp_action   (rsp.action)
);

@@ dv/tb_qos_deadband_frequency_governor.sv @@
// Testbench for the QoS dead-band frequency governor: drives core reports and APB
// writes, predicts each decision in a scoreboard class and checks every result.
// Depends on qdfg_pkg, qdfg_if and the top level qos_deadband_frequency_governor.
`timescale 1ns / 100ps

module tb_qos_deadband_frequency_governor;
    import qdfg_pkg::*;

    localparam int WATCHDOG_CYCLES = 400000;
    localparam int TAIL_CYCLES     = 4;
    localparam int RATE_TOP        = 8388607;

    typedef struct {
        logic [CORE_FIELD_W-1:0] core_index;
        logic                    has_app;
        logic signed [RATE_W-1:0] current_rate;
        logic signed [RATE_W-1:0] target_rate;
        logic [FREQ_W-1:0]       old_freq;
    } report_t;

    typedef struct {
        logic [FREQ_W-1:0] freq;
        action_t           act;
    } freq_decision_t;

    class governor_scoreboard;
        logic [FREQ_W-1:0]        max_freq;
        logic [FREQ_W-1:0]        min_freq;
        logic [MARGIN_W-1:0]      margin;
        logic [STEP_W-1:0]        step;
        logic signed [RATE_W-1:0] last_rate [NUM_CORES];
        freq_decision_t           pending_decisions [$];
        int                       mismatches;
        int                       checked;
        int                       action_hits [8];

        function new();
            max_freq = MAX_FREQ_RST;
            min_freq = MIN_FREQ_RST;
            margin   = MARGIN_RST;
            step     = STEP_RST;
            foreach (last_rate[i])
                last_rate[i] = RATE_NONE;
            foreach (action_hits[i])
                action_hits[i] = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_MAX_FREQ: max_freq = data[FREQ_W-1:0];
                REG_MIN_FREQ: min_freq = data[FREQ_W-1:0];
                REG_MARGIN:   margin   = data[MARGIN_W-1:0];
                REG_STEP:     step     = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(cfg_reg_t idx);
            case (idx)
                REG_MAX_FREQ: return DATA_W'(max_freq);
                REG_MIN_FREQ: return DATA_W'(min_freq);
                REG_MARGIN:   return DATA_W'(margin);
                default:      return DATA_W'(step);
            endcase
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        endfunction

        function freq_decision_t decide_freq(report_t r);
            freq_decision_t           d;
            logic signed [RATE_W-1:0] stored;
            bit                       have_slot;
            int                       rate2;
            int                       tgt2;
            int                       m;
            int                       bumped;
            have_slot = (r.core_index < NUM_CORES);
            stored = have_slot ? last_rate[r.core_index] : RATE_NONE;
            if (!r.has_app) begin
                d.freq = min_freq;
                d.act  = ACT_NO_APP;
            end
            else if (r.current_rate < 0) begin
                d.freq = max_freq;
                d.act  = ACT_NO_DATA;
            end
            else if (r.current_rate == stored) begin
                d.freq = r.old_freq;
                d.act  = ACT_STALE;
            end
            else begin
                if (have_slot)
                    last_rate[r.core_index] = r.current_rate;
                if (r.target_rate == 0) begin
                    d.freq = max_freq;
                    d.act  = ACT_UNSET;
                end
                else if (r.target_rate < 0) begin
                    d.freq = r.old_freq;
                    d.act  = ACT_ERROR;
                end
                else begin
                    // compare doubled values so an odd margin stays exact
                    rate2 = 2 * int'(r.current_rate);
                    tgt2  = 2 * int'(r.target_rate);
                    m     = int'(margin);
                    if (rate2 >= tgt2 - m && rate2 <= tgt2 + m) begin
                        d.freq = r.old_freq;
                        d.act  = ACT_HOLD;
                    end
                    else if (r.current_rate > r.target_rate) begin
                        d.freq = (r.old_freq >= step) ? r.old_freq - step : '0;
                        d.act  = ACT_DOWN;
                    end
                    else begin
                        bumped = int'(r.old_freq) + int'(step);
                        d.freq = (bumped > 65535) ? 16'hFFFF : bumped[FREQ_W-1:0];
                        d.act  = ACT_UP;
                    end
                end
            end
            return d;
        endfunction

        function void note_report(report_t r);
            pending_decisions.push_back(decide_freq(r));
        endfunction

        function void check_decision(logic [FREQ_W-1:0] freq, action_t act);
            freq_decision_t want;
            if (pending_decisions.size() == 0) begin
                flag("decision with none pending", 32'd0, 32'(freq));
                return;
            end
            want = pending_decisions.pop_front();
            checked++;
            action_hits[want.act]++;
            if (freq !== want.freq)
                flag("new_freq", 32'(want.freq), 32'(freq));
            if (act !== want.act)
                flag("action", 32'(want.act), 32'(act));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    bit                  quiet;
    bit                  hold_rsp;
    int                  accepted;
    logic signed [RATE_W-1:0] recent_rate [2**CORE_FIELD_W];
    governor_scoreboard  board;

    qdfg_req_if req_ch ();
    qdfg_rsp_if rsp_ch ();

    qos_deadband_frequency_governor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        repeat (WATCHDOG_CYCLES) @(posedge clk);
        $display("timeout with %0d decisions outstanding", board.pending_decisions.size());
        $display("status: fail");
        $finish;
    end

    // Result side: random back-pressure, off during the quiet stretch
    initial
    begin : rsp_driver
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !hold_rsp && (quiet || $urandom_range(99) >= 18);
        end
    end

    // Hold off the result side long enough for the block to stall its input
    initial
    begin : rsp_holdoff
        hold_rsp = 1'b0;
        wait (accepted >= 300);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (250) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_decision(rsp_ch.new_freq, rsp_ch.action);
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(input cfg_reg_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== board.reg_value(idx))
            board.flag("register readback", board.reg_value(idx), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        read_reg(REG_MAX_FREQ);
        read_reg(REG_MIN_FREQ);
        read_reg(REG_MARGIN);
        read_reg(REG_STEP);
    endtask

    // Junk in the upper data bits must be dropped by the register width
    task automatic apply_settings(input logic [FREQ_W-1:0] max_f, input logic [FREQ_W-1:0] min_f,
                                  input logic [MARGIN_W-1:0] mrg, input logic [STEP_W-1:0] stp);
        write_reg(REG_MAX_FREQ, {16'($urandom), max_f});
        write_reg(REG_MIN_FREQ, {16'($urandom), min_f});
        write_reg(REG_MARGIN, {16'($urandom), mrg});
        write_reg(REG_STEP, {20'($urandom), stp});
        check_regs();
    endtask

    task automatic offer_report(input report_t r);
        if (!quiet && $urandom_range(99) < 18)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while (!quiet && $urandom_range(99) < 18);
        end
        req_ch.valid        <= 1'b1;
        req_ch.core_index   <= r.core_index;
        req_ch.has_app      <= r.has_app;
        req_ch.current_rate <= r.current_rate;
        req_ch.target_rate  <= r.target_rate;
        req_ch.old_freq     <= r.old_freq;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_report(r);
        accepted++;
    endtask

    function automatic report_t mk_report(int core, int app, int rate, int target, int old);
        report_t r;
        r.core_index   = core[CORE_FIELD_W-1:0];
        r.has_app      = app[0];
        r.current_rate = rate[RATE_W-1:0];
        r.target_rate  = target[RATE_W-1:0];
        r.old_freq     = old[FREQ_W-1:0];
        return r;
    endfunction

    // Mostly rates near the target band or repeats of the last rate, some noise
    function automatic report_t random_report();
        report_t r;
        int      pick;
        int      t;
        int      v;
        int      span;
        r.core_index = CORE_FIELD_W'($urandom);
        r.has_app    = ($urandom_range(99) < 90);
        pick = $urandom_range(99);
        if (pick < 6)
            t = 0;
        else if (pick < 12)
            t = -int'($urandom_range(8388608, 1));
        else if (pick < 60)
            t = $urandom_range(4000, 1);
        else
            t = $urandom_range(RATE_TOP, 1);
        pick = $urandom_range(99);
        if (pick < 8)
            v = -int'($urandom_range(8388608, 1));
        else if (pick < 22)
            v = recent_rate[r.core_index];
        else if (pick < 75 && t > 0)
        begin
            span = int'(board.margin) / 2 + 3;
            v = t + int'($urandom_range(2 * span)) - span;
            if (v < 0)
                v = 0;
            if (v > RATE_TOP)
                v = RATE_TOP;
        end
        else
            v = $urandom;
        r.target_rate  = t[RATE_W-1:0];
        r.current_rate = v[RATE_W-1:0];
        recent_rate[r.core_index] = v[RATE_W-1:0];
        pick = $urandom_range(99);
        if (pick < 5)
            r.old_freq = FREQ_W'($urandom_range(150));
        else if (pick < 10)
            r.old_freq = FREQ_W'($urandom_range(65535, 65400));
        else
            r.old_freq = FREQ_W'($urandom);
        return r;
    endfunction

    task automatic run_random(input int count);
        report_t r;
        repeat (count)
        begin
            quiet <= (accepted >= 1000 && accepted < 1300);
            r = random_report();
            offer_report(r);
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_decisions.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        board               = new();
        accepted            = 0;
        quiet               = 1'b0;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.core_index   = '0;
        req_ch.has_app      = 1'b0;
        req_ch.current_rate = '0;
        req_ch.target_rate  = '0;
        req_ch.old_freq     = '0;
        foreach (recent_rate[i])
            recent_rate[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        check_regs();

        // Directed reports at reset settings
        offer_report(mk_report(0, 0, 500, 1000, 1234));
        offer_report(mk_report(1, 1, -1, 1000, 1234));
        offer_report(mk_report(1, 1, -8388608, 1000, 0));
        offer_report(mk_report(2, 1, 0, 0, 777));
        offer_report(mk_report(2, 1, 0, 5000, 777));
        offer_report(mk_report(3, 1, 100, -5, 900));
        offer_report(mk_report(3, 1, 101, -8388608, 900));
        offer_report(mk_report(4, 1, 1128, 1000, 2000));
        offer_report(mk_report(4, 1, 1129, 1000, 2000));
        offer_report(mk_report(4, 1, 872, 1000, 2000));
        offer_report(mk_report(4, 1, 871, 1000, 2000));
        offer_report(mk_report(5, 1, 9000, 1000, 50));
        offer_report(mk_report(5, 1, 10, 1000, 65500));
        offer_report(mk_report(6, 1, RATE_TOP, RATE_TOP, 65535));
        offer_report(mk_report(6, 1, 0, RATE_TOP, 0));
        offer_report(mk_report(7, 1, RATE_TOP, 1, 0));
        offer_report(mk_report(15, 1, RATE_TOP, RATE_TOP, 12345));
        offer_report(mk_report(15, 1, RATE_TOP, 1, 12345));
        offer_report(mk_report(15, 0, RATE_TOP, 1, 12345));
        offer_report(mk_report(8, 1, 1000, 1000, 4000));
        offer_report(mk_report(8, 1, 1001, 1000, 4000));
        offer_report(mk_report(9, 1, -1, -1, 0));
        offer_report(mk_report(9, 1, 5, 0, 65535));
        offer_report(mk_report(10, 1, 0, 1, 3000));

        run_random(350);
        settle();
        apply_settings(16'hFFFF, 16'h0000, 16'h0000, 12'hFFF);
        run_random(350);
        settle();
        apply_settings(16'h0000, 16'hFFFF, 16'hFFFF, 12'h000);
        run_random(350);
        settle();
        apply_settings(FREQ_W'($urandom), FREQ_W'($urandom),
                       MARGIN_W'($urandom_range(600, 2)), STEP_W'($urandom_range(4095, 1)));
        run_random(350);
        settle();
        apply_settings(FREQ_W'($urandom), FREQ_W'($urandom), 16'd1, 12'd1);
        run_random(350);
        settle();

        $display("summary: %0d reports over five register settings, %0d decisions checked",
                 accepted, board.checked);
        $display("summary: no_app %0d no_data %0d stale %0d unset %0d",
                 board.action_hits[ACT_NO_APP], board.action_hits[ACT_NO_DATA],
                 board.action_hits[ACT_STALE], board.action_hits[ACT_UNSET]);
        $display("summary: error %0d hold %0d down %0d up %0d",
                 board.action_hits[ACT_ERROR], board.action_hits[ACT_HOLD],
                 board.action_hits[ACT_DOWN], board.action_hits[ACT_UP]);
        if (board.mismatches == 0 && board.pending_decisions.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ qos_deadband_frequency_governor.f @@
rtl/qdfg_pkg.sv
rtl/qdfg_if.sv
rtl/qdfg_decide.sv
rtl/qos_deadband_frequency_governor.sv
rtl/qdfg_checker.sv
dv/tb_qos_deadband_frequency_governor.sv
